FILE: rtl/core/aikpw_pkg.sv
// shared constants, register codes and cordic step table for the arm ik pulse width unit
package aikpw_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 12;
    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int STEP_TAB_LEN        = 24;
    localparam int PRESCALE_SHIFT      = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_ARM_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOREARM_LEN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHOULDER_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ELBOW_OFFSET    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_OFFSET    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_OFFSET     = 3'd7;

    // reset values
    localparam logic [7:0] RST_BASE_HEIGHT     = 8'd70;
    localparam logic [8:0] RST_UPPER_ARM_LEN   = 9'd146;
    localparam logic [8:0] RST_FOREARM_LEN     = 9'd187;
    localparam logic [7:0] RST_BASE_OFFSET     = 8'd90;
    localparam logic [7:0] RST_SHOULDER_OFFSET = 8'd140;
    localparam logic [7:0] RST_ELBOW_OFFSET    = 8'd90;
    localparam logic [7:0] RST_PITCH_OFFSET    = 8'd90;
    localparam logic [7:0] RST_ROLL_OFFSET     = 8'd90;

    // pulse width conversion: divide by 9 through reciprocal, 2^27 / 9 rounded up
    localparam int          PW_W       = 15;
    localparam logic [23:0] DIV9_MULT  = 24'd14913081;
    localparam int          DIV9_SHIFT = 27;
    localparam logic signed [16:0] PW_BASE = 17'sd750;
    localparam logic signed [16:0] PW_MAX  = 17'sd16383;
    localparam logic signed [16:0] PW_MIN  = -17'sd16384;

    // atan(2^-i) in units of 2^-24 degree
    function automatic logic [29:0] step_deg24(input int i);
        logic [29:0] v;
        case (i)
            0:  v = 30'd754974720;
            1:  v = 30'd445687602;
            2:  v = 30'd235489088;
            3:  v = 30'd119537938;
            4:  v = 30'd60000934;
            5:  v = 30'd30029717;
            6:  v = 30'd15018523;
            7:  v = 30'd7509720;
            8:  v = 30'd3754917;
            9:  v = 30'd1877466;
            10: v = 30'd938734;
            11: v = 30'd469367;
            12: v = 30'd234684;
            13: v = 30'd117342;
            14: v = 30'd58671;
            15: v = 30'd29335;
            16: v = 30'd14668;
            17: v = 30'd7334;
            18: v = 30'd3667;
            19: v = 30'd1833;
            20: v = 30'd917;
            21: v = 30'd458;
            22: v = 30'd229;
            23: v = 30'd115;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // step angle rounded to frac fraction bits
    function automatic logic [29:0] step_angle(input int i, input int frac);
        logic [29:0] half;
        half = 30'd1 << (23 - frac);
        return (step_deg24(i) + half) >> (24 - frac);
    endfunction

endpackage

FILE: rtl/core/aikpw_cordic.sv
// pipelined vectoring cordic giving atan2(y, x) in fixed point degrees
module aikpw_cordic #(
    parameter int F  = aikpw_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int NS = aikpw_pkg::CORDIC_STAGES_DEF,
    parameter int IW = 30,
    parameter int CW = 56,
    parameter int ZW = 22
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [IW-1:0] i_y,
    input  logic signed [IW-1:0] i_x,
    output logic                 o_valid,
    output logic signed [ZW-1:0] o_angle
);

    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180 * (1 << F));

    logic signed [CW-1:0] r_x [NS+1];
    logic signed [CW-1:0] r_y [NS+1];
    logic signed [ZW-1:0] r_z [NS+1];
    logic [NS:0]          r_v;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    assign xs = CW'(i_x) <<< aikpw_pkg::PRESCALE_SHIFT;
    assign ys = CW'(i_y) <<< aikpw_pkg::PRESCALE_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[NS-1:0], i_valid};
        end
    end

    // left half plane folds over with a half turn start angle
    always_ff @(posedge i_clk) begin
        if (i_x < 0) begin
            r_x[0] <= -xs;
            r_y[0] <= -ys;
            r_z[0] <= (i_y >= 0) ? HALF_TURN : -HALF_TURN;
        end else begin
            r_x[0] <= xs;
            r_y[0] <= ys;
            r_z[0] <= '0;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        localparam logic signed [ZW-1:0] STEP = ZW'(aikpw_pkg::step_angle(i, F));
        always_ff @(posedge i_clk) begin
            if (r_y[i] > 0) begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + STEP;
            end else if (r_y[i] < 0) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - STEP;
            end else begin
                r_x[i+1] <= r_x[i];
                r_y[i+1] <= r_y[i];
                r_z[i+1] <= r_z[i];
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_angle = r_z[NS];

endmodule

FILE: rtl/core/arm_inverse_kinematics_to_pulse_width_unit.sv
// top level: five axis arm inverse kinematics to servo pulse widths
//
// Pulse i_start with a gripper target (x, y, z in mm, pitch and roll in whole
// degrees); o_busy never rises, so a new target may start on every clock.
// Each transaction passes through the front end, the bit serial square root
// pipeline (one root bit per stage), the cordic stages and the pulse width
// stages, and comes back in the order started, as one o_done strobe of one
// cycle with the five servo pulse widths and the reachable flag; the receiver
// cannot hold results off, so results must be taken when shown.
// Unreachable targets (acos argument out of range, zero shoulder to wrist
// distance or a zero link length) return reachable low and all widths zero.
// Configuration registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data and must only change while no transaction is in flight.
module arm_inverse_kinematics_to_pulse_width_unit #(
    parameter int ANGLE_FRAC_BITS = aikpw_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = aikpw_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic signed [9:0]                   i_target_x,
    input  logic signed [9:0]                   i_target_y,
    input  logic signed [9:0]                   i_target_z,
    input  logic signed [8:0]                   i_pitch_deg,
    input  logic signed [8:0]                   i_roll_deg,
    input  logic                                i_cfg_we,
    input  logic [aikpw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [aikpw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                o_done,
    output logic signed [14:0]                  o_base_pw,
    output logic signed [14:0]                  o_shoulder_pw,
    output logic signed [14:0]                  o_elbow_pw,
    output logic signed [14:0]                  o_wrist_pitch_pw,
    output logic signed [14:0]                  o_wrist_roll_pw,
    output logic                                o_reachable
);

    localparam int F   = ANGLE_FRAC_BITS;
    localparam int NS  = (CORDIC_STAGES < aikpw_pkg::STEP_TAB_LEN) ?
                         CORDIC_STAGES : aikpw_pkg::STEP_TAB_LEN;
    // square root operand width: radial distance squared scaled by 2^2F,
    // or the law of cosines discriminants scaled by 2^16
    localparam int SQW = (20 + 2 * F > 58) ? 20 + 2 * F : 58;
    localparam int RW  = SQW / 2;
    localparam int IW  = RW + 1;
    // 24 bit prescale plus cordic gain and diagonal growth
    localparam int CW  = IW + 26;
    localparam int ZW  = F + 10;
    // joint positions stay within +-2048 degrees
    localparam int PSW = F + 12;
    localparam int PMW = PSW + 7;
    localparam int AW  = 18;
    localparam int QW  = AW + 24 - aikpw_pkg::DIV9_SHIFT;

    typedef struct packed {
        logic signed [9:0]  x;
        logic signed [9:0]  y;
        logic signed [10:0] wz;
        logic signed [22:0] n;
        logic signed [22:0] m;
        logic signed [8:0]  p;
        logic signed [8:0]  r;
        logic               unr;
    } t_side;

    typedef struct packed {
        logic signed [8:0] p;
        logic signed [8:0] r;
        logic              unr;
    } t_tail;

    // degrees to fixed point position
    function automatic logic signed [PSW-1:0] fx_deg(input logic signed [9:0] d);
        return PSW'(d) <<< F;
    endfunction

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [7:0] r_base_height;
    logic [8:0] r_upper_len;
    logic [8:0] r_fore_len;
    logic [7:0] r_off [5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_height <= aikpw_pkg::RST_BASE_HEIGHT;
            r_upper_len   <= aikpw_pkg::RST_UPPER_ARM_LEN;
            r_fore_len    <= aikpw_pkg::RST_FOREARM_LEN;
            r_off[0]      <= aikpw_pkg::RST_BASE_OFFSET;
            r_off[1]      <= aikpw_pkg::RST_SHOULDER_OFFSET;
            r_off[2]      <= aikpw_pkg::RST_ELBOW_OFFSET;
            r_off[3]      <= aikpw_pkg::RST_PITCH_OFFSET;
            r_off[4]      <= aikpw_pkg::RST_ROLL_OFFSET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                aikpw_pkg::REG_BASE_HEIGHT:     r_base_height <= i_cfg_data[7:0];
                aikpw_pkg::REG_UPPER_ARM_LEN:   r_upper_len   <= i_cfg_data;
                aikpw_pkg::REG_FOREARM_LEN:     r_fore_len    <= i_cfg_data;
                aikpw_pkg::REG_BASE_OFFSET:     r_off[0]      <= i_cfg_data[7:0];
                aikpw_pkg::REG_SHOULDER_OFFSET: r_off[1]      <= i_cfg_data[7:0];
                aikpw_pkg::REG_ELBOW_OFFSET:    r_off[2]      <= i_cfg_data[7:0];
                aikpw_pkg::REG_PITCH_OFFSET:    r_off[3]      <= i_cfg_data[7:0];
                aikpw_pkg::REG_ROLL_OFFSET:     r_off[4]      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // link length products, refreshed from the registers every cycle
    logic [17:0] r_a3sq;
    logic [17:0] r_a4sq;
    logic [17:0] r_a34;
    logic [37:0] r_ksq;
    logic [18:0] k_val;

    assign k_val = {r_a34, 1'b0};

    always_ff @(posedge i_clk) begin
        r_a3sq <= {9'd0, r_upper_len} * {9'd0, r_upper_len};
        r_a4sq <= {9'd0, r_fore_len} * {9'd0, r_fore_len};
        r_a34  <= {9'd0, r_upper_len} * {9'd0, r_fore_len};
        r_ksq  <= {19'd0, k_val} * {19'd0, k_val};
    end

    // ---------------------------------------------------------------
    // front end: squares and law of cosines terms
    // ---------------------------------------------------------------
    logic              r_v1, r_v2, r_v3, r_v4;
    logic signed [9:0] r1_x, r1_y, r2_x, r2_y, r3_x, r3_y, r4_x, r4_y;
    logic signed [8:0] r1_p, r1_r, r2_p, r2_r, r3_p, r3_r, r4_p, r4_r;
    logic [18:0]       r1_xx, r1_yy;
    logic signed [10:0] r1_wz, r2_wz, r3_wz, r4_wz;
    logic [19:0]       r2_rsq, r3_rsq, r4_rsq;
    logic [19:0]       r2_wzsq;
    logic [20:0]       r3_sw;
    logic signed [22:0] r3_n, r3_m, r4_n, r4_m;
    logic [41:0]       r4_nsq, r4_msq;
    logic [38:0]       r4_d4;
    logic              r4_swz;

    logic signed [19:0] xx_s, yy_s;
    logic signed [21:0] wzsq_s;
    logic [20:0]        sw_val;
    logic signed [45:0] nsq_s, msq_s;

    assign xx_s   = i_target_x * i_target_x;
    assign yy_s   = i_target_y * i_target_y;
    assign wzsq_s = r1_wz * r1_wz;
    assign sw_val = {1'b0, r2_wzsq} + {1'b0, r2_rsq};
    assign nsq_s  = r3_n * r3_n;
    assign msq_s  = r3_m * r3_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: coordinate squares, wrist height above shoulder
        r1_x  <= i_target_x;
        r1_y  <= i_target_y;
        r1_p  <= i_pitch_deg;
        r1_r  <= i_roll_deg;
        r1_xx <= xx_s[18:0];
        r1_yy <= yy_s[18:0];
        r1_wz <= $signed({i_target_z[9], i_target_z}) - $signed({3'b000, r_base_height});
        // stage 2: radial distance squared, height squared
        r2_x    <= r1_x;
        r2_y    <= r1_y;
        r2_p    <= r1_p;
        r2_r    <= r1_r;
        r2_wz   <= r1_wz;
        r2_rsq  <= {1'b0, r1_xx} + {1'b0, r1_yy};
        r2_wzsq <= wzsq_s[19:0];
        // stage 3: shoulder to wrist distance squared and cosine numerators
        r3_x   <= r2_x;
        r3_y   <= r2_y;
        r3_p   <= r2_p;
        r3_r   <= r2_r;
        r3_wz  <= r2_wz;
        r3_rsq <= r2_rsq;
        r3_sw  <= sw_val;
        r3_n   <= $signed({5'd0, r_a3sq}) - $signed({5'd0, r_a4sq})
                  + $signed({2'd0, sw_val});
        r3_m   <= $signed({5'd0, r_a3sq}) + $signed({5'd0, r_a4sq})
                  - $signed({2'd0, sw_val});
        // stage 4: squared numerators and denominator
        r4_x   <= r3_x;
        r4_y   <= r3_y;
        r4_p   <= r3_p;
        r4_r   <= r3_r;
        r4_wz  <= r3_wz;
        r4_rsq <= r3_rsq;
        r4_n   <= r3_n;
        r4_m   <= r3_m;
        r4_nsq <= nsq_s[41:0];
        r4_msq <= msq_s[41:0];
        r4_d4  <= {21'd0, r_a3sq} * {18'd0, r3_sw};
        r4_swz <= (r3_sw == '0);
    end

    // stage 5: reach check exact on integers, root operands
    logic [41:0] d2_val, da_val, db_val, ksq_ext;
    logic        unr_val;
    logic [SQW-1:0] sq_in [3];

    assign d2_val  = {1'b0, r4_d4, 2'b00};
    assign ksq_ext = {4'd0, r_ksq};
    assign da_val  = d2_val - r4_nsq;
    assign db_val  = ksq_ext - r4_msq;
    assign unr_val = r4_swz || (r_a34 == '0) || (r4_nsq > d2_val) || (r4_msq > ksq_ext);
    assign sq_in[0] = {{(SQW-20){1'b0}}, r4_rsq} << (2 * F);
    assign sq_in[1] = {{(SQW-42){1'b0}}, da_val} << 16;
    assign sq_in[2] = {{(SQW-42){1'b0}}, db_val} << 16;

    // ---------------------------------------------------------------
    // square roots: one root bit per stage, three lanes in lock step
    // ---------------------------------------------------------------
    logic [SQW-1:0] r_sv [3][RW+1];
    logic [SQW-1:0] r_sr [3][RW+1];
    t_side          r_sb [RW+1];
    logic [RW:0]    r_sqv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqv <= '0;
        end else begin
            r_sqv <= {r_sqv[RW-1:0], r_v4};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sb[0] <= '{x: r4_x, y: r4_y, wz: r4_wz, n: r4_n, m: r4_m,
                     p: r4_p, r: r4_r, unr: unr_val};
        for (int j = 0; j < RW; j++) begin
            r_sb[j+1] <= r_sb[j];
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        always_ff @(posedge i_clk) begin
            r_sv[l][0] <= sq_in[l];
            r_sr[l][0] <= '0;
        end
        for (genvar j = 0; j < RW; j++) begin : g_bit
            localparam logic [SQW-1:0] BIT = {{(SQW-1){1'b0}}, 1'b1} << (SQW - 2 - 2 * j);
            logic [SQW-1:0] trial;
            assign trial = r_sr[l][j] + BIT;
            always_ff @(posedge i_clk) begin
                if (r_sv[l][j] >= trial) begin
                    r_sv[l][j+1] <= r_sv[l][j] - trial;
                    r_sr[l][j+1] <= (r_sr[l][j] >> 1) + BIT;
                end else begin
                    r_sv[l][j+1] <= r_sv[l][j];
                    r_sr[l][j+1] <= r_sr[l][j] >> 1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // angles: base atan2(x, y), shoulder elevation and the two acos terms
    // ---------------------------------------------------------------
    logic signed [IW-1:0] c_y [4];
    logic signed [IW-1:0] c_x [4];
    logic signed [ZW-1:0] c_ang [4];
    logic [3:0]           c_v;

    assign c_y[0] = IW'(r_sb[RW].x);
    assign c_x[0] = IW'(r_sb[RW].y);
    assign c_y[1] = IW'(r_sb[RW].wz) <<< F;
    assign c_x[1] = {1'b0, r_sr[0][RW][RW-1:0]};
    assign c_y[2] = {1'b0, r_sr[1][RW][RW-1:0]};
    assign c_x[2] = IW'(r_sb[RW].n) <<< 8;
    assign c_y[3] = {1'b0, r_sr[2][RW][RW-1:0]};
    assign c_x[3] = IW'(r_sb[RW].m) <<< 8;

    for (genvar c = 0; c < 4; c++) begin : g_cordic
        aikpw_cordic #(
            .F  (F),
            .NS (NS),
            .IW (IW),
            .CW (CW),
            .ZW (ZW)
        ) u_cordic (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_sqv[RW]),
            .i_y     (c_y[c]),
            .i_x     (c_x[c]),
            .o_valid (c_v[c]),
            .o_angle (c_ang[c])
        );
    end

    // pitch, roll and reach flag ride alongside the cordic stages
    t_tail r_tl [NS+1];

    always_ff @(posedge i_clk) begin
        r_tl[0] <= '{p: r_sb[RW].p, r: r_sb[RW].r, unr: r_sb[RW].unr};
        for (int i = 0; i < NS; i++) begin
            r_tl[i+1] <= r_tl[i];
        end
    end

    // ---------------------------------------------------------------
    // joint positions and pulse widths
    // ---------------------------------------------------------------
    logic [4:0] r_pv;
    logic [3:0] r_pu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else begin
            r_pv <= {r_pv[3:0], &c_v};
        end
    end

    always_ff @(posedge i_clk) begin
        r_pu <= {r_pu[2:0], r_tl[NS].unr};
    end

    logic signed [PSW-1:0] bas_x, a1_x, a2_x, elb_x;
    logic                  vert;

    assign bas_x = PSW'(c_ang[0]);
    assign a1_x  = PSW'(c_ang[1]);
    assign a2_x  = PSW'(c_ang[2]);
    assign elb_x = PSW'(c_ang[3]);
    // roll follows the base turn only for a straight up or down gripper
    assign vert  = (r_tl[NS].p == 9'sd90) || (r_tl[NS].p == -9'sd90);

    logic signed [PSW-1:0] r_p1_b, r_p1_e, r_p1_w, r_p1_shl, r_p1_pe;
    logic signed [PSW-1:0] r_pos [5];

    always_ff @(posedge i_clk) begin
        // base, elbow and roll positions; shoulder sum; pitch partial
        r_p1_b   <= bas_x + fx_deg($signed({2'b00, r_off[0]}));
        r_p1_e   <= fx_deg($signed({2'b00, r_off[2]}) + 10'sd90) - elb_x;
        r_p1_w   <= fx_deg($signed({r_tl[NS].r[8], r_tl[NS].r}) + $signed({2'b00, r_off[4]}))
                    - (vert ? bas_x : '0);
        r_p1_shl <= a1_x + a2_x;
        r_p1_pe  <= fx_deg($signed({r_tl[NS].p[8], r_tl[NS].p}) + 10'sd180) - elb_x;
        // shoulder and wrist pitch need the shoulder sum
        r_pos[0] <= r_p1_b;
        r_pos[1] <= r_p1_shl + fx_deg($signed({2'b00, r_off[1]}) - 10'sd90);
        r_pos[2] <= r_p1_e;
        r_pos[3] <= r_p1_pe - r_p1_shl + fx_deg($signed({2'b00, r_off[3]}));
        r_pos[4] <= r_p1_w;
    end

    logic              r_neg3 [5];
    logic [AW-1:0]     r_av   [5];
    logic              r_neg4 [5];
    logic [QW-1:0]     r_q    [5];
    logic [14:0]       r_pw   [5];
    logic              r_reach;

    for (genvar s = 0; s < 5; s++) begin : g_servo
        logic signed [PMW-1:0] prod;
        logic [PMW-1:0]        mag;
        logic [AW+23:0]        mq;
        logic signed [16:0]    qs;
        logic signed [16:0]    pw;

        // divide by 9 * 2^F toward zero: magnitude, shift, reciprocal multiply
        assign prod = PMW'(r_pos[s]) * PMW'(100);
        assign mag  = prod[PMW-1] ? PMW'(-prod) : PMW'(prod);
        assign mq   = {24'd0, r_av[s]} * {{AW{1'b0}}, aikpw_pkg::DIV9_MULT};
        assign qs   = r_neg4[s] ? -$signed({{(17-QW){1'b0}}, r_q[s]})
                                :  $signed({{(17-QW){1'b0}}, r_q[s]});
        assign pw   = qs + aikpw_pkg::PW_BASE;

        always_ff @(posedge i_clk) begin
            r_neg3[s] <= prod[PMW-1];
            r_av[s]   <= AW'(mag >> F);
            r_neg4[s] <= r_neg3[s];
            r_q[s]    <= mq[AW+23:aikpw_pkg::DIV9_SHIFT];
            if (r_pu[3]) begin
                r_pw[s] <= '0;
            end else if (pw > aikpw_pkg::PW_MAX) begin
                r_pw[s] <= aikpw_pkg::PW_MAX[14:0];
            end else if (pw < aikpw_pkg::PW_MIN) begin
                r_pw[s] <= aikpw_pkg::PW_MIN[14:0];
            end else begin
                r_pw[s] <= pw[14:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_reach <= !r_pu[3];
    end

    assign o_busy           = 1'b0;
    assign o_done           = r_pv[4];
    assign o_base_pw        = r_pw[0];
    assign o_shoulder_pw    = r_pw[1];
    assign o_elbow_pw       = r_pw[2];
    assign o_wrist_pitch_pw = r_pw[3];
    assign o_wrist_roll_pw  = r_pw[4];
    assign o_reachable      = r_reach;

endmodule

FILE: rtl/core/aikpw_checker.sv
// port level checks for the arm ik pulse width unit and their bind
module aikpw_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_start,
    input logic                             o_busy,
    input logic                             o_done,
    input logic signed [14:0]               o_base_pw,
    input logic signed [14:0]               o_shoulder_pw,
    input logic signed [14:0]               o_elbow_pw,
    input logic signed [14:0]               o_wrist_pitch_pw,
    input logic signed [14:0]               o_wrist_roll_pw,
    input logic                             o_reachable
);

    // the pipeline takes a transaction on every cycle
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !o_busy)
        else $error("busy raised while a transaction was offered");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("done strobe right after reset");

    // unreachable targets carry zero widths
    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_reachable) |-> (o_base_pw == '0 && o_shoulder_pw == '0 &&
        o_elbow_pw == '0 && o_wrist_pitch_pw == '0 && o_wrist_roll_pw == '0))
        else $error("nonzero width on an unreachable result");

endmodule

bind arm_inverse_kinematics_to_pulse_width_unit aikpw_checker u_aikpw_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_start          (i_start),
    .o_busy           (o_busy),
    .o_done           (o_done),
    .o_base_pw        (o_base_pw),
    .o_shoulder_pw    (o_shoulder_pw),
    .o_elbow_pw       (o_elbow_pw),
    .o_wrist_pitch_pw (o_wrist_pitch_pw),
    .o_wrist_roll_pw  (o_wrist_roll_pw),
    .o_reachable      (o_reachable)
);
